// ===== rtl/core/mps_pkg.sv =====
// ----------------------------------------------------------------------------
// mps_pkg
// Shared constants and types of the masked pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

    localparam int MAX_LEN      = 8;   // longest signature, 1..8
    localparam int NUM_PATTERNS = 2;   // active signatures, 1..2
    localparam int OFFSET_BITS  = 32;  // width of the running offset, 8..64

    localparam int SIG_SLOTS   = 2;
    localparam int BYTE_W      = 8;
    localparam int PAT_W       = 64;
    localparam int WILD_W      = 8;
    localparam int CFG_LEN_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int MATCH_OFF_W = 32;
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int WIN_W       = MAX_LEN * BYTE_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PAT_A  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WILD_A = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LEN_A  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PAT_B  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_WILD_B = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_LEN_B  = CFG_IDX_W'(5);

    typedef struct packed {
        logic [PAT_W-1:0]     pat;
        logic [WILD_W-1:0]    wild;
        logic [CFG_LEN_W-1:0] len;
    } t_sig_cfg;

    typedef t_sig_cfg [SIG_SLOTS-1:0] t_sig_cfg_arr;

    // newest byte in entry 0
    typedef logic [MAX_LEN-1:0][BYTE_W-1:0] t_hist;

    // matches caused by one byte, handed from the scan stage to the output stage
    typedef struct packed {
        logic [SIG_SLOTS-1:0]                  hit;
        logic [SIG_SLOTS-1:0][MATCH_OFF_W-1:0] start;
    } t_hit_pair;

endpackage

`default_nettype wire

// ===== rtl/core/masked_pattern_scanner_top.sv =====
// ----------------------------------------------------------------------------
// masked_pattern_scanner_top
// Scans a byte stream for two masked signatures and reports match offsets.
// ----------------------------------------------------------------------------
// Path: a byte passes the input register, and its matches the result register.
// Throughput: one byte per cycle while o_stall is low; a byte that completes
// both signatures sends its results one per cycle while i_stall is low.
// Reset: clears configuration, window, offset and fill count at once.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_pattern_scanner_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [mps_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [mps_pkg::BYTE_W-1:0]         i_data_byte,
    input  wire logic                               i_restart_region,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [mps_pkg::MATCH_OFF_W-1:0]         o_match_offset,
    output logic                                    o_pattern_index,
    output logic                                    o_last_match
);

    mps_pkg::t_sig_cfg_arr r_sig, n_sig;
    mps_pkg::t_hit_pair    s_pair;
    logic                  s_push;
    logic                  s_free;

    always_comb begin
        n_sig = r_sig;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                mps_pkg::REG_PAT_A:  n_sig[0].pat  = i_cfg_wdata;
                mps_pkg::REG_WILD_A: n_sig[0].wild = i_cfg_wdata[mps_pkg::WILD_W-1:0];
                mps_pkg::REG_LEN_A:  n_sig[0].len  = i_cfg_wdata[mps_pkg::CFG_LEN_W-1:0];
                mps_pkg::REG_PAT_B:  n_sig[1].pat  = i_cfg_wdata;
                mps_pkg::REG_WILD_B: n_sig[1].wild = i_cfg_wdata[mps_pkg::WILD_W-1:0];
                mps_pkg::REG_LEN_B:  n_sig[1].len  = i_cfg_wdata[mps_pkg::CFG_LEN_W-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig <= '0;
        end else begin
            r_sig <= n_sig;
        end
    end

    mps_scan_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sig            (r_sig),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_restart_region (i_restart_region),
        .i_free           (s_free),
        .o_push           (s_push),
        .o_pair           (s_pair)
    );

    mps_out_buf u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (s_push),
        .i_pair          (s_pair),
        .o_free          (s_free),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_match_offset  (o_match_offset),
        .o_pattern_index (o_pattern_index),
        .o_last_match    (o_last_match)
    );

    // matches are never pushed over a pending result
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push |-> s_free)
        else $error("result register overwritten");

    // only signature A can be followed by another result of the same byte
    a_first_is_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_match) |-> (o_pattern_index == 1'b0))
        else $error("non-last result is not signature A");

    // the B result follows right after the A result of the same byte
    a_b_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_match) |=>
            (o_valid && o_pattern_index && o_last_match))
        else $error("second result of a byte missing");

endmodule

`default_nettype wire

// ===== rtl/core/mps_sig_cmp.sv =====
// ----------------------------------------------------------------------------
// mps_sig_cmp
// Compares one masked signature against the newest bytes of the window.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_sig_cmp (
    input  wire mps_pkg::t_sig_cfg                    i_cfg,
    input  wire mps_pkg::t_hist                       i_hist,
    input  wire logic [mps_pkg::LEN_W-1:0]            i_seen,
    input  wire logic [mps_pkg::OFFSET_BITS-1:0]      i_offset,
    output logic                                      o_hit,
    output logic [mps_pkg::MATCH_OFF_W-1:0]           o_start
);

    logic [mps_pkg::LEN_W-1:0]       len_eff;
    logic [mps_pkg::MAX_LEN-1:0]     byte_ok;
    logic [mps_pkg::OFFSET_BITS-1:0] start_full;
    logic                            seen_ok;

    // lengths past the window are clamped
    always_comb begin
        if (i_cfg.len > mps_pkg::CFG_LEN_W'(mps_pkg::MAX_LEN)) begin
            len_eff = mps_pkg::LEN_W'(mps_pkg::MAX_LEN);
        end else begin
            len_eff = mps_pkg::LEN_W'(i_cfg.len);
        end
    end

    // signature byte j lines up with history entry len-1-j
    always_comb begin
        logic [mps_pkg::BYTE_W-1:0] have;
        for (int j = 0; j < mps_pkg::MAX_LEN; j++) begin
            have = '0;
            for (int i = 0; i < mps_pkg::MAX_LEN; i++) begin
                if (i + j + 1 == int'(len_eff)) begin
                    have = i_hist[i];
                end
            end
            byte_ok[j] = (j >= int'(len_eff)) || i_cfg.wild[j] ||
                         (have == i_cfg.pat[mps_pkg::BYTE_W*j +: mps_pkg::BYTE_W]);
        end
    end

    assign seen_ok    = (int'(i_seen) + 1) >= int'(len_eff);
    assign o_hit      = (len_eff != '0) && seen_ok && (&byte_ok);
    assign start_full = i_offset - mps_pkg::OFFSET_BITS'(len_eff) + mps_pkg::OFFSET_BITS'(1);
    assign o_start    = mps_pkg::MATCH_OFF_W'(start_full);

endmodule

`default_nettype wire

// ===== rtl/core/mps_scan_core.sv =====
// ----------------------------------------------------------------------------
// mps_scan_core
// Input register, byte window, offset and fill count, signature compares.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_scan_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire mps_pkg::t_sig_cfg_arr           i_sig,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [mps_pkg::BYTE_W-1:0]      i_data_byte,
    input  wire logic                            i_restart_region,
    input  wire logic                            i_free,
    output logic                                 o_push,
    output mps_pkg::t_hit_pair                   o_pair
);

    logic                            r_in_vld, n_in_vld;
    logic [mps_pkg::BYTE_W-1:0]      r_in_byte, n_in_byte;
    logic                            r_in_restart, n_in_restart;
    logic [mps_pkg::WIN_W-1:0]       r_win, n_win;
    logic [mps_pkg::OFFSET_BITS-1:0] r_off, n_off;
    logic [mps_pkg::LEN_W-1:0]       r_seen, n_seen;

    logic [mps_pkg::WIN_W-1:0]        eff_win;
    logic [mps_pkg::OFFSET_BITS-1:0]  eff_off;
    logic [mps_pkg::LEN_W-1:0]        eff_seen;
    logic [mps_pkg::WIN_W+mps_pkg::BYTE_W-1:0] hist_ext;
    mps_pkg::t_hist                   hist;
    logic                             advance;

    // a restart byte sees an empty window at offset zero
    assign eff_win  = r_in_restart ? '0 : r_win;
    assign eff_off  = r_in_restart ? '0 : r_off;
    assign eff_seen = r_in_restart ? '0 : r_seen;
    assign hist_ext = {eff_win, r_in_byte};
    assign hist     = hist_ext[mps_pkg::WIN_W-1:0];

    for (genvar k = 0; k < mps_pkg::SIG_SLOTS; k++) begin : g_sig
        if (k < mps_pkg::NUM_PATTERNS) begin : g_on
            mps_sig_cmp u_cmp (
                .i_cfg    (i_sig[k]),
                .i_hist   (hist),
                .i_seen   (eff_seen),
                .i_offset (eff_off),
                .o_hit    (o_pair.hit[k]),
                .o_start  (o_pair.start[k])
            );
        end else begin : g_off
            assign o_pair.hit[k]   = 1'b0;
            assign o_pair.start[k] = '0;
        end
    end

    // a byte without matches never waits on the output side
    assign advance = r_in_vld && ((~|o_pair.hit) || i_free);
    assign o_push  = advance && (|o_pair.hit);
    assign o_stall = r_in_vld && !advance;

    always_comb begin
        n_in_vld     = r_in_vld;
        n_in_byte    = r_in_byte;
        n_in_restart = r_in_restart;
        n_win        = r_win;
        n_off        = r_off;
        n_seen       = r_seen;
        if (!o_stall) begin
            n_in_vld     = i_valid;
            n_in_byte    = i_data_byte;
            n_in_restart = i_restart_region;
        end
        if (advance) begin
            n_win = hist;
            n_off = eff_off + mps_pkg::OFFSET_BITS'(1);
            if (int'(eff_seen) < mps_pkg::MAX_LEN - 1) begin
                n_seen = eff_seen + mps_pkg::LEN_W'(1);
            end else begin
                n_seen = eff_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_win    <= '0;
            r_off    <= '0;
            r_seen   <= '0;
        end else begin
            r_in_vld <= n_in_vld;
            r_win    <= n_win;
            r_off    <= n_off;
            r_seen   <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte    <= n_in_byte;
        r_in_restart <= n_in_restart;
    end

endmodule

`default_nettype wire

// ===== rtl/core/mps_out_buf.sv =====
// ----------------------------------------------------------------------------
// mps_out_buf
// Result register: holds the matches of one byte and sends them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module mps_out_buf (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    input  wire mps_pkg::t_hit_pair                i_pair,
    output logic                                   o_free,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [mps_pkg::MATCH_OFF_W-1:0]        o_match_offset,
    output logic                                   o_pattern_index,
    output logic                                   o_last_match
);

    logic [mps_pkg::SIG_SLOTS-1:0]                          r_hit, n_hit;
    logic [mps_pkg::SIG_SLOTS-1:0][mps_pkg::MATCH_OFF_W-1:0] r_start, n_start;
    logic xfer;

    assign o_valid         = |r_hit;
    assign o_pattern_index = !r_hit[0];
    assign o_last_match    = !(r_hit[0] && r_hit[1]);
    assign o_match_offset  = r_hit[0] ? r_start[0] : r_start[1];
    assign xfer            = o_valid && !i_stall;
    assign o_free          = !o_valid || (xfer && o_last_match);

    always_comb begin
        n_hit   = r_hit;
        n_start = r_start;
        if (i_push) begin
            n_hit   = i_pair.hit;
            n_start = i_pair.start;
        end else if (xfer) begin
            if (o_last_match) begin
                n_hit = '0;
            end else begin
                n_hit[0] = 1'b0;  // A went out, B remains
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= '0;
        end else begin
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
    end

endmodule

`default_nettype wire
